[rtl/height_to_normal_map_assert.svh]
// Assertion macros for the height-to-normal-map block.
// Included by the top level; no other dependencies.
`ifndef HEIGHT_TO_NORMAL_MAP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, disabled while in reset
`define HNM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("height_to_normal_map assertion failed");
// Checked property, also evaluated during reset
`define HNM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("height_to_normal_map assertion failed");
`else
`define HNM_ASSERT(label, prop)
`define HNM_ASSERT_ALWAYS(label, prop)
`endif

`endif

[rtl/hnm_pkg.sv]
// Package for the height-to-normal-map block: beat types, register
// indexes, state codes, neighbor tables and a wrap function. No dependencies.
`timescale 1ns / 1ps

package hnm_pkg;

    localparam int COORD_W   = 8;
    localparam int SAMPLE_W  = 16;
    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int MAG_W     = 45;
    localparam int MAG_LIM   = 30;

    localparam logic [SIZE_W-1:0] MAX_SIZE = 9'd256;

    // z sum is constant: twelve times one unit of 2^24
    localparam logic [MAG_W-1:0] Z_SUM = 45'd201326592;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PARALLAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Neighbor offsets, and each neighbor's weight in the x and y slope sums
    localparam logic signed [1:0] NB_DX [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                                -2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] NB_DY [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                                2'sd0, -2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] WT_X  [8] = '{-2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                                2'sd1, 2'sd1, 2'sd0, -2'sd1};
    localparam logic signed [1:0] WT_Y  [8] = '{2'sd0, -2'sd1, -2'sd1, -2'sd1,
                                                2'sd0, 2'sd1, 2'sd1, 2'sd1};

    typedef struct packed {
        logic                cmd;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SAMPLE_W-1:0] height_sample;
    } in_item_t;

    typedef struct packed {
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [15:0] normal_z;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_MUL,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    // One wrapped step of a coordinate within size n
    function automatic logic [COORD_W-1:0] wrap_step(
        input logic [COORD_W-1:0] c,
        input logic signed [1:0]  d,
        input logic [SIZE_W-1:0]  n
    );
        logic [SIZE_W-1:0] up;
        logic [SIZE_W-1:0] dn;
        up = {1'b0, c} + 9'd1;
        dn = (c == '0) ? (n - 9'd1) : ({1'b0, c} - 9'd1);
        if (d == 2'sd1)
            wrap_step = (up == n) ? '0 : up[COORD_W-1:0];
        else if (d == -2'sd1)
            wrap_step = dn[COORD_W-1:0];
        else
            wrap_step = c;
    endfunction

endpackage

[rtl/height_to_normal_map.sv]
// A compute beat runs 8 modulo steps, 8 store reads, multiply, scaling steps,
// 3 squares, 31 root steps, 3 divides and an output load, which waits while
// the output stalls. A store beat per cycle is taken while idle; no new beat
// is taken until a compute beat has loaded its result into the output register.
// Reset: registers return to 256 (parallax 1.0, size 256x256); the height
// store is not cleared and reads as undefined until written. Needs hnm_pkg.
`timescale 1ns / 1ps
`include "height_to_normal_map_assert.svh"

module height_to_normal_map (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  hnm_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hnm_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hnm_pkg::CFG_W-1:0]         cfg_data
);
    import hnm_pkg::*;

    // Configuration and control registers
    state_t              state_reg, state_next;
    logic [15:0]         parallax_reg;
    logic [SIZE_W-1:0]   width_reg, height_reg;
    logic [4:0]          cnt_reg, cnt_next;
    logic [1:0]          comp_reg, comp_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers
    logic [COORD_W-1:0]  x_rem_reg, x_rem_next, y_rem_reg, y_rem_next;
    logic [24:0]         zs_reg, zs_next;
    logic signed [18:0]  dx_acc_reg, dx_acc_next, dy_acc_reg, dy_acc_next;
    logic [MAG_W-1:0]    ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic                sx_neg_reg, sx_neg_next, sy_neg_reg, sy_neg_next;
    logic [61:0]         sum_reg, sum_next;
    logic [62:0]         root_reg, root_next;
    logic [49:0]         rem_reg, rem_next;
    logic [16:0]         q_reg, q_next;
    logic [15:0]         res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [15:0]         res_z_reg, res_z_next;
    out_item_t           out_data_reg, out_data_next;

    // Height store, single port
    logic [SAMPLE_W-1:0] mem [0:65535];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_en;
    logic [15:0]         rd_addr;
    logic                wr_en;

    // Combinational helpers
    logic [SIZE_W-1:0]   wcl, hcl;
    logic [24:0]         zs_prod;
    logic [16:0]         x_sub, y_sub;
    logic [2:0]          k_rd, k_acc;
    logic [COORD_W-1:0]  nb_x, nb_y;
    logic signed [18:0]  h_ext;
    logic signed [44:0]  prod_x, prod_y;
    logic [44:0]         mag_x, mag_y;
    logic [29:0]         sq_op;
    logic [59:0]         sq_prod;
    logic [61:0]         root_bit;
    logic [62:0]         root_trial;
    logic [30:0]         len;
    logic [29:0]         div_m;
    logic                div_neg;
    logic [49:0]         div_base, div_mterm, div_sh;
    logic [15:0]         q_sat;

    // Clamp sizes in use to 1..256
    assign wcl = (width_reg == '0) ? 9'd1 : ((width_reg > MAX_SIZE) ? MAX_SIZE : width_reg);
    assign hcl = (height_reg == '0) ? 9'd1 : ((height_reg > MAX_SIZE) ? MAX_SIZE : height_reg);
    assign zs_prod = {16'b0, wcl} * {9'b0, parallax_reg};

    // Restoring modulo step
    assign x_sub = {8'b0, wcl} << cnt_reg[2:0];
    assign y_sub = {8'b0, hcl} << cnt_reg[2:0];

    // Neighbor address for the read issued this cycle
    assign k_rd    = cnt_reg[2:0];
    assign k_acc   = cnt_reg[2:0] - 3'd1;
    assign nb_x    = wrap_step(x_rem_reg, NB_DX[k_rd], wcl);
    assign nb_y    = wrap_step(y_rem_reg, NB_DY[k_rd], hcl);
    assign rd_addr = {nb_y, nb_x};
    assign h_ext   = $signed({3'b0, rd_data_reg});

    // Slope products and magnitudes (sum is twice the product)
    assign prod_x = $signed({1'b0, zs_reg}) * dx_acc_reg;
    assign prod_y = $signed({1'b0, zs_reg}) * dy_acc_reg;
    assign mag_x  = prod_x[44] ? 45'(-prod_x) : 45'(prod_x);
    assign mag_y  = prod_y[44] ? 45'(-prod_y) : 45'(prod_y);

    // Square of one scaled component
    assign sq_op   = (comp_reg == COMP_X) ? ax_reg[29:0] :
                     (comp_reg == COMP_Y) ? ay_reg[29:0] : az_reg[29:0];
    assign sq_prod = sq_op * sq_op;

    // Root step
    assign root_bit   = 62'd1 << {cnt_reg, 1'b0};
    assign root_trial = root_reg + {1'b0, root_bit};

    // Divide setup and step
    assign len       = root_reg[30:0];
    assign div_neg   = (comp_reg == COMP_X) ? sx_neg_reg :
                       (comp_reg == COMP_Y) ? sy_neg_reg : 1'b0;
    assign div_m     = sq_op;
    assign div_base  = ({19'b0, len} << 16) + {19'b0, len};
    assign div_mterm = {20'b0, div_m} << 16;
    assign div_sh    = {18'b0, len, 1'b0} << cnt_reg;

    assign wr_en = in_valid && in_ready && (in_data.cmd == CMD_STORE);

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg;
        x_rem_next     = x_rem_reg;
        y_rem_next     = y_rem_reg;
        zs_next        = zs_reg;
        dx_acc_next    = dx_acc_reg;
        dy_acc_next    = dy_acc_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        sum_next       = sum_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_z_next     = res_z_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        q_sat          = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_data.cmd == CMD_COMPUTE)
                begin
                    x_rem_next  = in_data.x;
                    y_rem_next  = in_data.y;
                    zs_next     = zs_prod;
                    dx_acc_next = '0;
                    dy_acc_next = '0;
                    cnt_next    = 5'd7;
                    state_next  = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if ({9'b0, x_rem_reg} >= x_sub)
                    x_rem_next = x_rem_reg - x_sub[7:0];
                if ({9'b0, y_rem_reg} >= y_sub)
                    y_rem_next = y_rem_reg - y_sub[7:0];
                if (cnt_reg == '0)
                    state_next = ST_READ;
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            ST_READ:
            begin
                rd_en = !cnt_reg[3];
                // accumulate the sample read on the previous cycle
                if (cnt_reg != '0)
                begin
                    if (WT_X[k_acc] == 2'sd1)
                        dx_acc_next = dx_acc_reg + h_ext;
                    else if (WT_X[k_acc] == -2'sd1)
                        dx_acc_next = dx_acc_reg - h_ext;
                    if (WT_Y[k_acc] == 2'sd1)
                        dy_acc_next = dy_acc_reg + h_ext;
                    else if (WT_Y[k_acc] == -2'sd1)
                        dy_acc_next = dy_acc_reg - h_ext;
                end
                if (cnt_reg[3])
                    state_next = ST_MUL;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_MUL:
            begin
                ax_next     = {mag_x[43:0], 1'b0};
                ay_next     = {mag_y[43:0], 1'b0};
                az_next     = Z_SUM;
                sx_neg_next = prod_x[44];
                sy_neg_next = prod_y[44];
                state_next  = ST_NORM;
            end
            ST_NORM:
            begin
                // common right shift until all magnitudes fit 30 bits
                if ((ax_reg | ay_reg | az_reg) >> MAG_LIM != '0)
                begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                    az_next = az_reg >> 1;
                end
                else
                begin
                    sum_next   = '0;
                    comp_next  = COMP_X;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sum_next = sum_reg + {2'b0, sq_prod};
                if (comp_reg == COMP_Z)
                begin
                    root_next  = '0;
                    cnt_next   = 5'd30;
                    state_next = ST_SQRT;
                end
                else
                    comp_next = comp_reg + 2'd1;
            end
            ST_SQRT:
            begin
                if ({1'b0, sum_reg} >= root_trial)
                begin
                    sum_next  = sum_reg - root_trial[61:0];
                    root_next = (root_reg >> 1) + {1'b0, root_bit};
                end
                else
                    root_next = root_reg >> 1;
                if (cnt_reg == '0)
                begin
                    comp_next  = COMP_X;
                    state_next = ST_DIV_INIT;
                end
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            ST_DIV_INIT:
            begin
                rem_next   = div_neg ? (div_base - div_mterm) : (div_base + div_mterm);
                q_next     = '0;
                cnt_next   = 5'd16;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_reg >= div_sh)
                begin
                    rem_next         = rem_reg - div_sh;
                    q_next[cnt_reg]  = 1'b1;
                end
                q_sat = q_next[16] ? 16'hFFFF : q_next[15:0];
                if (cnt_reg == '0)
                begin
                    case (comp_reg)
                        COMP_X:  res_x_next = q_sat;
                        COMP_Y:  res_y_next = q_sat;
                        default: res_z_next = q_sat;
                    endcase
                    if (comp_reg == COMP_Z)
                        state_next = ST_OUT;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DIV_INIT;
                    end
                end
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.normal_x = res_x_reg;
                    out_data_next.normal_y = res_y_reg;
                    out_data_next.normal_z = res_z_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= COMP_X;
            out_valid_reg <= 1'b0;
            parallax_reg  <= 16'd256;
            width_reg     <= MAX_SIZE;
            height_reg    <= MAX_SIZE;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PARALLAX: parallax_reg <= cfg_data;
                    CFG_WIDTH:    width_reg    <= cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:   height_reg   <= cfg_data[SIZE_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_rem_reg    <= x_rem_next;
        y_rem_reg    <= y_rem_next;
        zs_reg       <= zs_next;
        dx_acc_reg   <= dx_acc_next;
        dy_acc_reg   <= dy_acc_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        az_reg       <= az_next;
        sx_neg_reg   <= sx_neg_next;
        sy_neg_reg   <= sy_neg_next;
        sum_reg      <= sum_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_z_reg    <= res_z_next;
        out_data_reg <= out_data_next;
    end

    // Height store: write on store beats, else a registered read when enabled
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{in_data.y, in_data.x}] <= in_data.height_sample;
        else if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `HNM_ASSERT(a_sq_fits, (state_reg == ST_SQ) |-> ((ax_reg | ay_reg | az_reg) >> MAG_LIM == '0))
    `HNM_ASSERT(a_len_nonzero, (state_reg == ST_DIV_INIT) |-> (len != '0))
    `HNM_ASSERT(a_out_load, (state_reg == ST_OUT && (!out_valid_reg || out_ready)) |=> (out_valid_reg && state_reg == ST_IDLE))
    `HNM_ASSERT_ALWAYS(a_no_read_on_store, !(wr_en && rd_en))

endmodule

[tb/tb_top.sv]
// Self-checking testbench for height_to_normal_map: directed table, then
// random store/query traffic over several register settings and idle mixes.
// Depends on hnm_pkg and the height_to_normal_map RTL.
`timescale 1ns / 1ps

module tb_top;

    import hnm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unused index, must be ignored
    localparam int  STORE_SIZE = 65536;
    localparam int  BEATS_PER_PHASE = 60;
    localparam int  NUM_PHASES = 8;
    localparam out_item_t FLAT_NORMAL = '{16'd32768, 16'd32768, 16'd65535};

    // Neighbor offsets, counterclockwise starting at +x
    localparam int OFF_X [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    localparam int OFF_Y [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    typedef struct {
        logic        cmd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] h;       // sample for a store, fill value for a query
        bit          typed;
        out_item_t   want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Shadow copy of the block's state
    logic [15:0] height_mem [STORE_SIZE];
    bit          written    [STORE_SIZE];
    logic [15:0] gain_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    out_item_t normal_q [$];
    int        errors;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        hold_cycles;

    height_to_normal_map uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned eff_size(logic [8:0] v);
        if (v == 9'd0)
            return 1;
        if (v > 9'd256)
            return 256;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Map one signed component to Q0.16 as c*0.5+0.5, rounded, saturated
    function automatic logic [15:0] to_unorm(longint v, int sh, longint unsigned len);
        longint unsigned m;
        longint unsigned num;
        longint unsigned q;
        m = magnitude(v) >> sh;
        num = 65537 * len;
        if (v < 0)
            num = num - m * 65536;
        else
            num = num + m * 65536;
        q = num / (2 * len);
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    // Normal at a query point from the shadow height store and registers
    function automatic out_item_t predict_normal(logic [7:0] qx, logic [7:0] qy);
        int unsigned w;
        int unsigned h;
        int unsigned cx;
        int unsigned cy;
        int unsigned nx;
        int unsigned ny;
        int a;
        int b;
        int sh;
        longint zs;
        longint hc;
        longint dz [8];
        longint sx;
        longint sy;
        longint sz;
        longint unsigned mx;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mc;
        longint unsigned len;
        out_item_t r;
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        cx = qx % w;
        cy = qy % h;
        zs = longint'(w) * longint'(gain_reg);
        hc = height_mem[cy * 256 + cx];
        for (int k = 0; k < 8; k++)
        begin
            nx = (int'(cx) + OFF_X[k] + int'(w)) % int'(w);
            ny = (int'(cy) + OFF_Y[k] + int'(h)) % int'(h);
            dz[k] = zs * (longint'(height_mem[ny * 256 + nx]) - hc);
        end
        sx = 0;
        sy = 0;
        sz = 0;
        // Diamond pairs first (even neighbors), then square pairs (odd)
        for (int k = 0; k < 8; k++)
        begin
            a = (k < 4) ? 2 * k : 2 * (k - 4) + 1;
            b = (a + 2) % 8;
            sx += OFF_Y[a] * dz[b] - dz[a] * OFF_Y[b];
            sy += dz[a] * OFF_X[b] - OFF_X[a] * dz[b];
            sz += longint'(OFF_X[a] * OFF_Y[b] - OFF_Y[a] * OFF_X[b]) <<< 24;
        end
        mx = magnitude(sx);
        if (magnitude(sy) > mx)
            mx = magnitude(sy);
        if (magnitude(sz) > mx)
            mx = magnitude(sz);
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30))
            sh++;
        ma = magnitude(sx) >> sh;
        mb = magnitude(sy) >> sh;
        mc = magnitude(sz) >> sh;
        len = int_sqrt(ma * ma + mb * mb + mc * mc);
        if (len == 0)
            len = 1;
        r.normal_x = to_unorm(sx, sh, len);
        r.normal_y = to_unorm(sy, sh, len);
        r.normal_z = to_unorm(sz, sh, len);
        return r;
    endfunction

    // Present one input beat; update the model when it is accepted
    task automatic send_beat(in_item_t it, bit typed, out_item_t want);
        if (($urandom % 100) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (($urandom % 100) < tx_idle_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (it.cmd == CMD_STORE)
        begin
            height_mem[{it.y, it.x}] = it.height_sample;
            written[{it.y, it.x}] = 1'b1;
        end
        else
            normal_q.push_back(typed ? want : predict_normal(it.x, it.y));
        @(negedge clk);
    endtask

    // Query a point, first storing the point or any neighbor that was never written
    task automatic query_point(logic [7:0] qx, logic [7:0] qy, bit rand_fill,
                               logic [15:0] fill, bit typed, out_item_t want);
        int unsigned w;
        int unsigned h;
        int unsigned nx;
        int unsigned ny;
        in_item_t it;
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        for (int k = -1; k < 8; k++)
        begin
            nx = (int'(qx % w) + ((k < 0) ? 0 : OFF_X[k]) + int'(w)) % int'(w);
            ny = (int'(qy % h) + ((k < 0) ? 0 : OFF_Y[k]) + int'(h)) % int'(h);
            if (!written[ny * 256 + nx])
            begin
                it.cmd = CMD_STORE;
                it.x = nx[7:0];
                it.y = ny[7:0];
                it.height_sample = rand_fill ? 16'($urandom) : fill;
                send_beat(it, 1'b0, want);
            end
        end
        it.cmd = CMD_COMPUTE;
        it.x = qx;
        it.y = qy;
        it.height_sample = 16'($urandom);
        send_beat(it, typed, want);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PARALLAX)
            gain_reg = val;
        else if (idx == CFG_WIDTH)
            width_reg = val[8:0];
        else if (idx == CFG_HEIGHT)
            height_reg = val[8:0];
    endtask

    // Let all pending normals drain, then the block's own latency
    task automatic drain();
        while (normal_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (($urandom % 100) >= rx_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (normal_q.size() == 0)
            begin
                $error("unexpected result beat %h", out_data);
                errors++;
            end
            else
            begin
                out_item_t exp_n;
                exp_n = normal_q.pop_front();
                if (out_data.normal_x !== exp_n.normal_x)
                begin
                    $error("normal_x expected %0d actual %0d", exp_n.normal_x,
                           out_data.normal_x);
                    errors++;
                end
                if (out_data.normal_y !== exp_n.normal_y)
                begin
                    $error("normal_y expected %0d actual %0d", exp_n.normal_y,
                           out_data.normal_y);
                    errors++;
                end
                if (out_data.normal_z !== exp_n.normal_z)
                begin
                    $error("normal_z expected %0d actual %0d", exp_n.normal_z,
                           out_data.normal_z);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        dir_row_t  rows [$];
        in_item_t  it;
        out_item_t none;
        logic [15:0] ph_gain  [NUM_PHASES];
        logic [8:0]  ph_width [NUM_PHASES];
        logic [8:0]  ph_height[NUM_PHASES];
        logic [7:0]  last_x;
        logic [7:0]  last_y;
        int unsigned pick;
        int unsigned w;
        int unsigned h;

        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 0;
        none = '0;
        gain_reg = 16'd256;
        width_reg = 9'd256;
        height_reg = 9'd256;
        foreach (written[i])
            written[i] = 1'b0;
        last_x = 0;
        last_y = 0;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: flat fields, edge wraps, extreme samples
        rows = '{
            '{CMD_COMPUTE, 8'd0,   8'd0,   16'h1234, 1'b1, FLAT_NORMAL},
            '{CMD_STORE,   8'd1,   8'd0,   16'hFFFF, 1'b0, none},
            '{CMD_STORE,   8'd255, 8'd255, 16'h0000, 1'b0, none},
            '{CMD_COMPUTE, 8'd0,   8'd0,   16'h0000, 1'b0, none},
            '{CMD_STORE,   8'd0,   8'd0,   16'hFFFF, 1'b0, none},
            '{CMD_COMPUTE, 8'd0,   8'd0,   16'h0000, 1'b0, none},
            '{CMD_STORE,   8'd0,   8'd255, 16'h0000, 1'b0, none},
            '{CMD_STORE,   8'd255, 8'd0,   16'h0000, 1'b0, none},
            '{CMD_COMPUTE, 8'd0,   8'd0,   16'h0000, 1'b0, none},
            '{CMD_COMPUTE, 8'd255, 8'd255, 16'hFFFF, 1'b0, none},
            '{CMD_COMPUTE, 8'd128, 8'd77,  16'h0000, 1'b1, FLAT_NORMAL},
            '{CMD_COMPUTE, 8'd200, 8'd3,   16'h0000, 1'b1, FLAT_NORMAL},
            '{CMD_STORE,   8'd201, 8'd3,   16'hFFFF, 1'b0, none},
            '{CMD_COMPUTE, 8'd200, 8'd3,   16'h0000, 1'b0, none},
            '{CMD_STORE,   8'd200, 8'd4,   16'hFFFF, 1'b0, none},
            '{CMD_COMPUTE, 8'd200, 8'd3,   16'h0000, 1'b0, none},
            '{CMD_STORE,   8'd199, 8'd2,   16'h8000, 1'b0, none},
            '{CMD_COMPUTE, 8'd200, 8'd3,   16'h0000, 1'b0, none}
        };
        foreach (rows[i])
        begin
            if (rows[i].cmd == CMD_COMPUTE)
                query_point(rows[i].x, rows[i].y, 1'b0, rows[i].h, rows[i].typed,
                            rows[i].want);
            else
            begin
                it = '{CMD_STORE, rows[i].x, rows[i].y, rows[i].h};
                send_beat(it, 1'b0, none);
            end
        end
        in_valid <= 1'b0;
        drain();

        // Register settings per phase: zero and oversize sizes, tiny images
        ph_gain   = '{16'd256, 16'd0,     16'hFFFF, 16'hFFFF, 16'd1,   16'd37,  16'h8000, 16'd300};
        ph_width  = '{9'd256,  9'd1,      9'd256,   9'd0,     9'd511,  9'd3,    9'd17,    9'd200};
        ph_height = '{9'd256,  9'd1,      9'd256,   9'd0,     9'd300,  9'd5,    9'd256,   9'd64};

        write_reg(CFG_SPARE, 16'hFFFF);
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(CFG_PARALLAX, ph_gain[ph]);
            write_reg(CFG_WIDTH, {7'd0, ph_width[ph]});
            write_reg(CFG_HEIGHT, {7'd0, ph_height[ph]});
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 54; rx_idle_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_idle_pct = 54; end
                default: begin tx_idle_pct = 32; rx_idle_pct = 32; end
            endcase
            // Long output hold-off so the block backs up into its input
            if (ph == 4)
                hold_cycles = 600;
            w = eff_size(width_reg);
            h = eff_size(height_reg);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                pick = $urandom % 100;
                if (pick < 55)
                begin
                    // Queries stay in two small windows so neighbor fills stay few
                    last_x = 8'($urandom_range(0, 7));
                    last_y = 8'($urandom_range(0, 7) + (($urandom % 2) * 64));
                    query_point(last_x, last_y, 1'b1, 16'h0, 1'b0, none);
                end
                else
                begin
                    it.cmd = CMD_STORE;
                    if (pick < 80)
                    begin
                        it.x = 8'($urandom);
                        it.y = 8'($urandom);
                    end
                    else
                    begin
                        // Disturb the neighborhood of the last query
                        it.x = 8'((last_x % w + $urandom_range(0, 2) + w - 1) % w);
                        it.y = 8'((last_y % h + $urandom_range(0, 2) + h - 1) % h);
                    end
                    case ($urandom % 8)
                        0: it.height_sample = 16'h0000;
                        1: it.height_sample = 16'hFFFF;
                        default: it.height_sample = 16'($urandom);
                    endcase
                    send_beat(it, 1'b0, none);
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
